[sv/clcd_pkg.sv]
// Shared types, constants and the control store of the character LCD nibble writer.
package clcd_pkg;

    localparam int DATA_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int UPC_W    = 4;

    // Action codes of an input item.
    localparam logic [2:0] ACT_CHAR    = 3'd0;
    localparam logic [2:0] ACT_COMMAND = 3'd1;
    localparam logic [2:0] ACT_CURSOR  = 3'd2;
    localparam logic [2:0] ACT_CLEAR   = 3'd3;
    localparam logic [2:0] ACT_POWERUP = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_WAIT  = 2'd1;

    localparam logic [DATA_W-1:0] ENABLE_HOLD_RST = 8'd1;
    localparam logic [DATA_W-1:0] CLEAR_WAIT_RST  = 8'd3;

    localparam logic [DATA_W-1:0] CURSOR_BASE = 8'h80;
    localparam logic [DATA_W-1:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    localparam logic [DATA_W-1:0] CMD_FUNC_8BIT = 8'h33;
    localparam logic [DATA_W-1:0] CMD_FUNC_4BIT = 8'h32;
    localparam logic [DATA_W-1:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [DATA_W-1:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [DATA_W-1:0] CMD_ENTRY     = 8'h06;
    localparam logic [DATA_W-1:0] CMD_CLEAR     = 8'h01;

    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram addresses.
    localparam upc_t UPC_CHAR    = 4'd0;
    localparam upc_t UPC_COMMAND = 4'd1;
    localparam upc_t UPC_CURSOR  = 4'd2;
    localparam upc_t UPC_CLEAR   = 4'd3;
    localparam upc_t UPC_INIT0   = 4'd4;
    localparam upc_t UPC_INIT1   = 4'd5;
    localparam upc_t UPC_INIT2   = 4'd6;
    localparam upc_t UPC_INIT3   = 4'd7;
    localparam upc_t UPC_INIT4   = 4'd8;
    localparam upc_t UPC_INIT5   = 4'd9;

    typedef enum logic [1:0] {
        SRC_DATA   = 2'd0,
        SRC_CURSOR = 2'd1,
        SRC_CONST  = 2'd2
    } src_sel_t;

    // One control word sends one byte as four pin results.
    typedef struct packed {
        src_sel_t          src;
        logic              rs;
        logic [DATA_W-1:0] const_byte;
        logic              done;
        logic              long_wait;
        upc_t              next_pc;
    } uword_t;

    // Control from the sequencer to the datapath for one pin result.
    typedef struct packed {
        logic              emit;
        src_sel_t          src;
        logic              rs;
        logic [DATA_W-1:0] const_byte;
        logic              low_half;
        logic              enable;
        logic              final_step;
        logic              long_wait;
    } ctrl_t;

    function automatic uword_t mk_uword(input src_sel_t src, input logic rs,
                                        input logic [DATA_W-1:0] cb, input logic done,
                                        input logic long_wait, input upc_t next_pc);
        uword_t w;
        w.src        = src;
        w.rs         = rs;
        w.const_byte = cb;
        w.done       = done;
        w.long_wait  = long_wait;
        w.next_pc    = next_pc;
        return w;
    endfunction

    function automatic uword_t clcd_ucode(input upc_t pc);
        uword_t w;
        case (pc)
            UPC_CHAR:    w = mk_uword(SRC_DATA, 1'b1, '0, 1'b1, 1'b0, UPC_CHAR);
            UPC_COMMAND: w = mk_uword(SRC_DATA, 1'b0, '0, 1'b1, 1'b0, UPC_CHAR);
            UPC_CURSOR:  w = mk_uword(SRC_CURSOR, 1'b0, '0, 1'b1, 1'b0, UPC_CHAR);
            UPC_CLEAR:   w = mk_uword(SRC_CONST, 1'b0, CMD_CLEAR, 1'b1, 1'b1, UPC_CHAR);
            UPC_INIT0:   w = mk_uword(SRC_CONST, 1'b0, CMD_FUNC_8BIT, 1'b0, 1'b0, UPC_INIT1);
            UPC_INIT1:   w = mk_uword(SRC_CONST, 1'b0, CMD_FUNC_4BIT, 1'b0, 1'b0, UPC_INIT2);
            UPC_INIT2:   w = mk_uword(SRC_CONST, 1'b0, CMD_FUNC_SET, 1'b0, 1'b0, UPC_INIT3);
            UPC_INIT3:   w = mk_uword(SRC_CONST, 1'b0, CMD_DISP_ON, 1'b0, 1'b0, UPC_INIT4);
            UPC_INIT4:   w = mk_uword(SRC_CONST, 1'b0, CMD_ENTRY, 1'b0, 1'b0, UPC_INIT5);
            UPC_INIT5:   w = mk_uword(SRC_CONST, 1'b0, CMD_CLEAR, 1'b1, 1'b1, UPC_CHAR);
            default:     w = mk_uword(SRC_CONST, 1'b0, '0, 1'b1, 1'b0, UPC_CHAR);
        endcase
        return w;
    endfunction

    // Dispatch table: entry address for each action code.
    function automatic upc_t clcd_entry(input logic [2:0] action);
        upc_t pc;
        case (action)
            ACT_CHAR:    pc = UPC_CHAR;
            ACT_COMMAND: pc = UPC_COMMAND;
            ACT_CURSOR:  pc = UPC_CURSOR;
            ACT_CLEAR:   pc = UPC_CLEAR;
            ACT_POWERUP: pc = UPC_INIT0;
            default:     pc = UPC_CHAR;
        endcase
        return pc;
    endfunction

endpackage

[sv/clcd_sequencer.sv]
// Microprogram sequencer: program counter, nibble phase counter and control store.
module clcd_sequencer
    import clcd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] action,
    input  logic       slot_free,
    output logic       idle,
    output ctrl_t      ctrl
);

    logic       busy_reg, busy_next;
    upc_t       pc_reg, pc_next;
    logic [1:0] phase_reg, phase_next;
    uword_t     uw;

    always_comb
    begin
        uw              = clcd_ucode(pc_reg);
        ctrl.emit       = busy_reg && slot_free;
        ctrl.src        = uw.src;
        ctrl.rs         = uw.rs;
        ctrl.const_byte = uw.const_byte;
        ctrl.low_half   = phase_reg[1];
        ctrl.enable     = ~phase_reg[0];
        ctrl.final_step = uw.done && (phase_reg == 2'd3);
        ctrl.long_wait  = uw.long_wait;
        idle            = ~busy_reg;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        pc_next    = pc_reg;
        phase_next = phase_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            pc_next    = clcd_entry(action);
            phase_next = 2'd0;
        end
        else if (ctrl.emit)
        begin
            phase_next = phase_reg + 2'd1;
            if (phase_reg == 2'd3)
            begin
                if (uw.done)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pc_next = uw.next_pc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            pc_reg    <= UPC_CHAR;
            phase_reg <= 2'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            pc_reg    <= pc_next;
            phase_reg <= phase_next;
        end
    end

endmodule

[sv/clcd_datapath.sv]
// Datapath: operand and configuration registers, byte and nibble selection, result register.
module clcd_datapath
    import clcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic [DATA_W-1:0]    data_byte,
    input  logic [5:0]           column,
    input  logic [1:0]           row,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  ctrl_t                ctrl,
    input  logic                 out_ready,
    output logic                 slot_free,
    output logic                 out_valid,
    output logic                 reg_select,
    output logic [3:0]           bus_nibble,
    output logic                 enable_pin,
    output logic [DATA_W-1:0]    wait_ms,
    output logic                 last_of_run
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] cursor_reg;
    logic [DATA_W-1:0] hold_reg, clear_wait_reg;
    logic              out_valid_reg, out_valid_next;
    logic              rs_reg, en_reg, last_reg;
    logic [3:0]        nib_reg;
    logic [DATA_W-1:0] wait_reg;
    logic [DATA_W-1:0] sel_byte;
    logic [DATA_W-1:0] wait_sel;
    logic [3:0]        nib_sel;

    always_comb
    begin
        case (ctrl.src)
            SRC_DATA:   sel_byte = data_reg;
            SRC_CURSOR: sel_byte = cursor_reg;
            SRC_CONST:  sel_byte = ctrl.const_byte;
            default:    sel_byte = ctrl.const_byte;
        endcase
        nib_sel = ctrl.low_half ? sel_byte[3:0] : sel_byte[7:4];
        if (ctrl.final_step && ctrl.long_wait)
        begin
            wait_sel = clear_wait_reg;
        end
        else if (ctrl.enable)
        begin
            wait_sel = hold_reg;
        end
        else
        begin
            wait_sel = '0;
        end
        slot_free      = ~out_valid_reg || out_ready;
        out_valid_next = ctrl.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_reg       <= ENABLE_HOLD_RST;
            clear_wait_reg <= CLEAR_WAIT_RST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_write && cfg_index == CFG_ENABLE_HOLD)
            begin
                hold_reg <= cfg_data;
            end
            if (cfg_write && cfg_index == CFG_CLEAR_WAIT)
            begin
                clear_wait_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg   <= data_byte;
            cursor_reg <= CURSOR_BASE + ROW_OFFSET[row] + {2'b00, column};
        end
        if (ctrl.emit)
        begin
            rs_reg   <= ctrl.rs;
            nib_reg  <= nib_sel;
            en_reg   <= ctrl.enable;
            wait_reg <= wait_sel;
            last_reg <= ctrl.final_step;
        end
    end

    assign out_valid   = out_valid_reg;
    assign reg_select  = rs_reg;
    assign bus_nibble  = nib_reg;
    assign enable_pin  = en_reg;
    assign wait_ms     = wait_reg;
    assign last_of_run = last_reg;

endmodule

[sv/char_lcd_nibble_writer.sv]
// Top level of the character LCD nibble writer for a 4-bit parallel bus.
//
//  Channel   Direction  Signals                                   Content
//  s_axis    in         s_axis_tvalid/tready/tdata               one action request
//  m_axis    out        m_axis_tvalid/tready/tdata/tuser/tlast   one pin state
//  cfg       in         cfg_valid/cfg_ready/cfg_index/cfg_data   register write
//
// An accepted item is latched, then the microprogram sends each byte as
// four pin results, one per cycle while the output side takes them: a
// character, command or cursor move gives 4 results, a clear 4, the
// power-up sequence 24. The sequencer steps once per pin result and
// takes a new request only when idle.
// Reset brings the sequencer to idle, drops the result valid and loads the
// enable hold with 1 ms and the clear wait with 3 ms. A stall on m_axis
// freezes the sequencer; s_axis is taken only while the sequencer is idle.
// Action codes 5 to 7 are accepted and give no result.
module char_lcd_nibble_writer
    import clcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // Bits from low: action[2:0], data_byte[10:3], column[16:11], row[18:17], zero pad.
    input  logic [23:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // Bits from low: bus_nibble[3:0], enable_pin[4], wait_ms[12:5], zero pad.
    output logic [15:0]          m_axis_tdata,
    // Bits from low: reg_select[0].
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    logic              idle;
    logic              accept;
    logic              start;
    logic              slot_free;
    ctrl_t             ctrl;
    logic [3:0]        bus_nibble;
    logic              enable_pin;
    logic [DATA_W-1:0] wait_ms;
    logic [2:0]        action;

    // The request channel is open whenever no byte sequence is running.
    assign s_axis_tready = idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign action        = s_axis_tdata[2:0];
    // Only defined action codes start the microprogram.
    assign start         = accept && (action <= ACT_POWERUP);
    assign cfg_ready     = 1'b1;

    clcd_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (action),
        .slot_free (slot_free),
        .idle      (idle),
        .ctrl      (ctrl)
    );

    clcd_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (start),
        .data_byte   (s_axis_tdata[10:3]),
        .column      (s_axis_tdata[16:11]),
        .row         (s_axis_tdata[18:17]),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctrl        (ctrl),
        .out_ready   (m_axis_tready),
        .slot_free   (slot_free),
        .out_valid   (m_axis_tvalid),
        .reg_select  (m_axis_tuser),
        .bus_nibble  (bus_nibble),
        .enable_pin  (enable_pin),
        .wait_ms     (wait_ms),
        .last_of_run (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, wait_ms, enable_pin, bus_nibble};

    // A started request keeps the input channel closed in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !s_axis_tready)
        else $error("request channel open right after a start");

    // A result that is not the last of its run means the sequence is still running.
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("sequencer idle while a run is unfinished");

    // Every run ends on a result with the enable line low.
    a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && enable_pin) |-> !m_axis_tlast)
        else $error("run ended with enable high");

    // A stalled result is never overwritten by the sequencer.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !ctrl.emit)
        else $error("result register overwritten while stalled");

endmodule

[test/tb_char_lcd_nibble_writer.sv]
// Self-checking testbench for the character LCD nibble writer.
module tb_char_lcd_nibble_writer
    import clcd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Action codes 5 to 7 are not defined and must produce no pin states.
    localparam logic [2:0] ACT_LAST_CODE = 3'd7;

    // Cycles allowed after the last expected pin state for the block to go idle.
    // An item is latched and then gives at most 24 pin results.
    localparam int DRAIN_CYCLES = 40;

    // The slowest correct run is roughly 210 items of up to 24 transfers, each
    // of them stalled at random; this limit lies above that run.
    localparam int LIMIT_NS = 1_500_000;

    // The power-up sequence, in the order the display expects it.
    localparam logic [DATA_W-1:0] POWERUP_SEQ [6] = '{CMD_FUNC_8BIT, CMD_FUNC_4BIT,
        CMD_FUNC_SET, CMD_DISP_ON, CMD_ENTRY, CMD_CLEAR};

    // One pin state as it appears on the output stream.
    typedef struct {
        logic                rs;
        logic [3:0]          nibble;
        logic                en;
        logic [DATA_W-1:0]   hold_ms;
        logic                last;
    } pin_state_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [15:0]          m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    // Pin states predicted for accepted actions, oldest first.
    pin_state_t        pending_pins[$];
    int                mismatch_count = 0;
    int                pin_count = 0;

    // The testbench's own copy of the two timing registers.
    logic [DATA_W-1:0] cur_pulse_ms = ENABLE_HOLD_RST;
    logic [DATA_W-1:0] cur_clear_ms = CLEAR_WAIT_RST;

    // Idle pattern state of the sending and the receiving side.
    int                send_left = 0;
    bit                send_quiet = 1'b0;
    int                recv_left = 0;
    bit                recv_quiet = 1'b0;

    char_lcd_nibble_writer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard limit on the run in case the block hangs.
    initial
    begin
        #(LIMIT_NS);
        $display("FAIL char_lcd_nibble_writer");
        $finish;
    end

    // Idle cycles before the next transfer. Stretches of 4 to 24 items are
    // either free of idling or draw a random idle gap per item, so that
    // gaps land on every phase of a byte and back-to-back traffic is seen too.
    function automatic int draw_gap(inout int stretch_left, inout bit quiet);
        if (stretch_left == 0)
        begin
            stretch_left = $urandom_range(4, 24);
            quiet = ($urandom_range(0, 2) == 0);
        end
        stretch_left--;
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    // A byte goes out as high nibble with the strobe high, then with it low,
    // then the same two states for the low nibble.
    function automatic void queue_byte_pins(input logic rs, input logic [DATA_W-1:0] b);
        pin_state_t p;
        for (int half = 0; half < 2; half++)
        begin
            p.rs = rs;
            p.nibble = (half == 0) ? b[7:4] : b[3:0];
            p.last = 1'b0;
            p.en = 1'b1;
            p.hold_ms = cur_pulse_ms;
            pending_pins.push_back(p);
            p.en = 1'b0;
            p.hold_ms = '0;
            pending_pins.push_back(p);
        end
    endfunction

    // Predicts every pin state one action causes and queues them.
    function automatic void queue_action_pins(input logic [2:0] action,
                                              input logic [DATA_W-1:0] data_byte,
                                              input logic [5:0] column,
                                              input logic [1:0] row);
        logic [DATA_W-1:0] addr;
        bit                long_wait;
        long_wait = 1'b0;
        case (action)
            ACT_CHAR:    queue_byte_pins(1'b1, data_byte);
            ACT_COMMAND: queue_byte_pins(1'b0, data_byte);
            ACT_CURSOR:
            begin
                // The address simply wraps within one byte; no column clamping.
                addr = CURSOR_BASE + ROW_OFFSET[row] + DATA_W'(column);
                queue_byte_pins(1'b0, addr);
            end
            ACT_CLEAR:
            begin
                queue_byte_pins(1'b0, CMD_CLEAR);
                long_wait = 1'b1;
            end
            ACT_POWERUP:
            begin
                foreach (POWERUP_SEQ[i])
                    queue_byte_pins(1'b0, POWERUP_SEQ[i]);
                long_wait = 1'b1;
            end
            default:
                return;
        endcase
        // The final state of a clear or power-up holds for the clear wait.
        if (long_wait)
            pending_pins[pending_pins.size() - 1].hold_ms = cur_clear_ms;
        pending_pins[pending_pins.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] pin state %0d: %s", $time, pin_count, msg);
        mismatch_count++;
    endtask

    // Offers one action on the input stream and predicts its pin states once
    // the transfer has taken place. tvalid stays high on return so that a
    // following item without a gap is offered back to back.
    task automatic send_action(input logic [2:0] action, input logic [DATA_W-1:0] data_byte,
                               input logic [5:0] column, input logic [1:0] row);
        int gap;
        gap = draw_gap(send_left, send_quiet);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, row, column, data_byte, action};
        do
            @(posedge clk);
        while (!(s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1));
        queue_action_pins(action, data_byte, column, row);
    endtask

    // Stops the input stream, waits for every predicted pin state and then
    // gives the block time to finish an action that produces nothing.
    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes both timing registers back to back; only called while idle.
    task automatic set_timing(input logic [DATA_W-1:0] pulse_ms,
                              input logic [DATA_W-1:0] clear_ms);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ENABLE_HOLD;
        cfg_data <= pulse_ms;
        do
            @(posedge clk);
        while (!(cfg_valid === 1'b1 && cfg_ready === 1'b1));
        cur_pulse_ms = pulse_ms;
        cfg_index <= CFG_CLEAR_WAIT;
        cfg_data <= clear_ms;
        do
            @(posedge clk);
        while (!(cfg_valid === 1'b1 && cfg_ready === 1'b1));
        cur_clear_ms = clear_ms;
        cfg_valid <= 1'b0;
    endtask

    // Random actions until the given number of defined ones has been sent.
    // Undefined codes are mixed in as noise, and every field is random
    // whether the action uses it or not.
    task automatic run_random_actions(input int count);
        int          sent;
        int          pick;
        logic [2:0]  action;
        logic [5:0]  column;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                action = 3'($urandom_range(ACT_POWERUP + 3'd1, ACT_LAST_CODE));
            else if (pick < 16)
                action = ACT_POWERUP;
            else if (pick < 26)
                action = ACT_CLEAR;
            else if (pick < 50)
                action = ACT_CURSOR;
            else if (pick < 75)
                action = ACT_COMMAND;
            else
                action = ACT_CHAR;
            // Mostly columns a real display has, sometimes the ones beyond.
            column = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(40, 63))
                                                 : 6'($urandom_range(0, 39));
            send_action(action, DATA_W'($urandom_range(0, 255)), column,
                        2'($urandom_range(0, 3)));
            if (action <= ACT_POWERUP)
                sent++;
        end
    endtask

    // Field extremes, every action, address wrap, out-of-range columns and
    // the undefined codes, then random traffic, all with the timing registers at reset values.
    task automatic test_directed_actions();
        send_action(ACT_CHAR, 8'h00, 6'd0, 2'd0);
        send_action(ACT_CHAR, 8'hFF, 6'd63, 2'd3);
        send_action(ACT_COMMAND, 8'hA5, 6'd0, 2'd0);
        send_action(ACT_COMMAND, 8'h5A, 6'd63, 2'd3);
        send_action(ACT_CURSOR, 8'h00, 6'd0, 2'd0);
        send_action(ACT_CURSOR, 8'hFF, 6'd39, 2'd1);
        send_action(ACT_CURSOR, 8'h00, 6'd20, 2'd2);
        send_action(ACT_CURSOR, 8'h00, 6'd39, 2'd3);
        // Row 3 with the widest column runs past 0xFF and wraps.
        send_action(ACT_CURSOR, 8'h00, 6'd63, 2'd3);
        send_action(ACT_CURSOR, 8'h00, 6'd63, 2'd1);
        send_action(ACT_CURSOR, 8'h00, 6'd40, 2'd0);
        send_action(ACT_CLEAR, 8'hFF, 6'd63, 2'd3);
        send_action(ACT_POWERUP, 8'h00, 6'd0, 2'd0);
        send_action(ACT_POWERUP + 3'd1, 8'hFF, 6'd63, 2'd3);
        send_action(ACT_POWERUP + 3'd2, 8'h00, 6'd0, 2'd0);
        send_action(ACT_LAST_CODE, 8'hFF, 6'd63, 2'd3);
        send_action(ACT_CHAR, 8'h41, 6'd5, 2'd2);
        run_random_actions(40);
        wait_for_idle();
    endtask

    // Both timings at zero: every state carries a zero hold.
    task automatic test_zero_timing();
        set_timing('0, '0);
        send_action(ACT_CLEAR, 8'h00, 6'd0, 2'd0);
        send_action(ACT_POWERUP, 8'h00, 6'd0, 2'd0);
        run_random_actions(35);
        wait_for_idle();
    endtask

    // Both timings at their maximum.
    task automatic test_max_timing();
        set_timing('1, '1);
        send_action(ACT_CLEAR, 8'h00, 6'd0, 2'd0);
        send_action(ACT_POWERUP, 8'h00, 6'd0, 2'd0);
        run_random_actions(35);
        wait_for_idle();
    endtask

    // A few random timing settings with random traffic under each.
    task automatic test_random_timing();
        for (int round = 0; round < 3; round++)
        begin
            set_timing(DATA_W'($urandom_range(0, 255)), DATA_W'($urandom_range(0, 255)));
            run_random_actions(25);
            wait_for_idle();
        end
    endtask

    // Output side: stalls at random, and checks each pin state transfer
    // against the oldest prediction, field by field.
    initial
    begin
        int         gap;
        pin_state_t got;
        pin_state_t want;
        wait (rst_n === 1'b1);
        gap = draw_gap(recv_left, recv_quiet);
        forever
        begin
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
            got.rs = m_axis_tuser;
            got.nibble = m_axis_tdata[3:0];
            got.en = m_axis_tdata[4];
            got.hold_ms = m_axis_tdata[12:5];
            got.last = m_axis_tlast;
            if (pending_pins.size() == 0)
                report_mismatch("no pin state was expected");
            else
            begin
                want = pending_pins.pop_front();
                if (got.rs !== want.rs)
                    report_mismatch($sformatf("reg_select %b, expected %b", got.rs, want.rs));
                if (got.nibble !== want.nibble)
                    report_mismatch($sformatf("bus_nibble %h, expected %h",
                                              got.nibble, want.nibble));
                if (got.en !== want.en)
                    report_mismatch($sformatf("enable_pin %b, expected %b", got.en, want.en));
                if (got.hold_ms !== want.hold_ms)
                    report_mismatch($sformatf("wait_ms %0d, expected %0d",
                                              got.hold_ms, want.hold_ms));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              got.last, want.last));
            end
            pin_count++;
            gap = draw_gap(recv_left, recv_quiet);
        end
    end

    // Main sequence: one reset, then each test in turn, then the verdict.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_actions();
        test_zero_timing();
        test_max_timing();
        test_random_timing();
        if (mismatch_count == 0)
            $display("PASS char_lcd_nibble_writer");
        else
            $display("FAIL char_lcd_nibble_writer");
        $finish;
    end

endmodule
